// ===== rtl/fprt_pkg.sv =====
// ----------------------------------------------------------------------------
// fprt_pkg
// Shared constants for the FIFO page residency tracker: field widths,
// register indexes, register reset values and parameter defaults.
// ----------------------------------------------------------------------------
package fprt_pkg;

  // parameter defaults
  localparam int DEF_MAX_PAGES  = 1024;
  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_ADDR_BITS  = 32;

  // configuration register widths
  localparam int OFFSET_CFG_W = 5;
  localparam int PCOUNT_W     = 11;
  localparam int FCAP_W       = 7;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;

  // result field widths
  localparam int PHYS_W  = 32;
  localparam int TOTAL_W = 32;

  // largest usable offset width
  localparam logic [OFFSET_CFG_W-1:0] OFFSET_BITS_MAX = OFFSET_CFG_W'(20);

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_OFFSET_BITS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PAGE_COUNT  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_FRAME_CAP   = cfg_idx_t'(2);

  // register reset values
  localparam logic [OFFSET_CFG_W-1:0] RST_OFFSET_BITS = OFFSET_CFG_W'(12);
  localparam logic [PCOUNT_W-1:0]     RST_PAGE_COUNT  = PCOUNT_W'(1024);
  localparam logic [FCAP_W-1:0]       RST_FRAME_CAP   = FCAP_W'(64);

endpackage

// ===== rtl/fifo_page_residency_tracker_top.sv =====
// ----------------------------------------------------------------------------
// fifo_page_residency_tracker_top
// FIFO page replacement: translates an address, tracks resident pages in a
// bitmap memory and evicts the oldest page from an arrival ring when full.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes S_EVAL, then S_SET, where its result is
//   registered once the output register is free. No new request is taken
//   until then; bitmap steps: read the page, clear the victim, set the page.
// Reset: control state clears at once, then a clearing pass writes every
//   bitmap entry to zero, during which requests are stalled.
//   Configuration writes are taken at any time.
module fifo_page_residency_tracker_top #(
  parameter int MAX_PAGES  = fprt_pkg::DEF_MAX_PAGES,
  parameter int MAX_FRAMES = fprt_pkg::DEF_MAX_FRAMES,
  parameter int ADDR_BITS  = fprt_pkg::DEF_ADDR_BITS,
  localparam int PAGE_W    = $clog2(MAX_PAGES)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [fprt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fprt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ADDR_BITS-1:0]              in_virtual_address,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fprt_pkg::PHYS_W-1:0]       out_physical_address,
  output logic                              out_address_invalid,
  output logic                              out_page_hit,
  output logic                              out_eviction_done,
  output logic [PAGE_W-1:0]                 out_evicted_page,
  output logic [fprt_pkg::TOTAL_W-1:0]      out_hit_total,
  output logic [fprt_pkg::TOTAL_W-1:0]      out_fault_total,
  output logic [fprt_pkg::TOTAL_W-1:0]      out_eviction_total
);

  // ring addressing and resident count widths
  localparam int RING_AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RT_W    = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W   = $clog2(2 * MAX_FRAMES) + 1;
  localparam int CAP_W   = (RT_W > fprt_pkg::FCAP_W) ? RT_W : fprt_pkg::FCAP_W;
  // width for the page bound check: the page number width, but at least 17 bits
  localparam int CMP_W   = (ADDR_BITS > 17) ? ADDR_BITS : 17;

  localparam logic [fprt_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    S_CLEAR,  // sweep the bitmap to zero after reset
    S_IDLE,   // take a request, read bitmap and ring head
    S_EVAL,   // decide hit/fault/evict, clear victim, update ring and counts
    S_SET     // mark the faulting page resident, hand the result over
  } state_t;

  state_t state_r;

  // configuration registers
  logic [fprt_pkg::OFFSET_CFG_W-1:0] offset_bits_r;
  logic [fprt_pkg::PCOUNT_W-1:0]     page_count_r;
  logic [fprt_pkg::FCAP_W-1:0]       frame_cap_r;

  // tracking state
  logic [RING_AW-1:0]  ring_head_r;
  logic [RT_W-1:0]     resident_total_r;
  logic [fprt_pkg::TOTAL_W-1:0] hit_cnt_r;
  logic [fprt_pkg::TOTAL_W-1:0] fault_cnt_r;
  logic [fprt_pkg::TOTAL_W-1:0] evict_cnt_r;
  logic [PAGE_W-1:0]   clr_idx_r;

  // request in flight
  logic [ADDR_BITS-1:0] vaddr_r;
  logic [PAGE_W-1:0]    page_r;
  logic                 invalid_r;
  logic                 fault_r;
  logic                 evict_r;
  logic [PAGE_W-1:0]    victim_r;

  // memory read data
  logic                 map_rd_r;
  logic [PAGE_W-1:0]    ring_rd_r;

  // output registers
  logic                         out_valid_r;
  logic [fprt_pkg::PHYS_W-1:0]  out_phys_r;
  logic                         out_invalid_r;
  logic                         out_hit_r;
  logic                         out_evict_r;
  logic [PAGE_W-1:0]            out_victim_r;
  logic [fprt_pkg::TOTAL_W-1:0] out_hit_tot_r;
  logic [fprt_pkg::TOTAL_W-1:0] out_fault_tot_r;
  logic [fprt_pkg::TOTAL_W-1:0] out_evict_tot_r;

  // memories
  logic                 map_mem  [MAX_PAGES];
  logic [PAGE_W-1:0]    ring_mem [MAX_FRAMES];

  // --------------------------------------------------------------------------
  // Request decode: clamp offset width and page limit, split the address.
  // --------------------------------------------------------------------------
  logic [fprt_pkg::OFFSET_CFG_W-1:0] obits;
  logic [ADDR_BITS-1:0]              in_page;
  logic [CMP_W-1:0]                  page_limit;
  logic                              in_invalid;
  logic                              in_accept;

  always_comb begin
    obits = (offset_bits_r > fprt_pkg::OFFSET_BITS_MAX) ? fprt_pkg::OFFSET_BITS_MAX
                                                         : offset_bits_r;
    in_page = in_virtual_address >> obits;
    page_limit = (CMP_W'(page_count_r) > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES)
                                                              : CMP_W'(page_count_r);
    in_invalid = CMP_W'(in_page) >= page_limit;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Eviction decision and ring bookkeeping for the request in S_EVAL.
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0]   cap;
  logic               ring_full;
  logic               is_fault;
  logic               is_evict;
  logic [SUM_W-1:0]   tail_sum;
  logic [RING_AW-1:0] ring_tail;
  logic [RING_AW-1:0] head_inc;

  always_comb begin
    if (frame_cap_r == '0) begin
      cap = CAP_W'(1);
    end else if (CAP_W'(frame_cap_r) > CAP_W'(MAX_FRAMES)) begin
      cap = CAP_W'(MAX_FRAMES);
    end else begin
      cap = CAP_W'(frame_cap_r);
    end
    ring_full = CAP_W'(resident_total_r) >= cap;
    is_fault  = !invalid_r && !map_rd_r;
    is_evict  = is_fault && ring_full;
    // new entry goes behind the resident pages; with an eviction the head
    // moves up one and the count stays, so the slot is the same
    tail_sum  = SUM_W'(ring_head_r) + SUM_W'(resident_total_r);
    ring_tail = (tail_sum >= SUM_W'(MAX_FRAMES)) ? RING_AW'(tail_sum - SUM_W'(MAX_FRAMES))
                                                 : RING_AW'(tail_sum);
    head_inc  = (ring_head_r == RING_AW'(MAX_FRAMES - 1)) ? '0 : ring_head_r + 1'b1;
  end

  // --------------------------------------------------------------------------
  // Bitmap write port: clearing sweep, victim clear, page set.
  // --------------------------------------------------------------------------
  logic              map_we;
  logic [PAGE_W-1:0] map_wa;
  logic              map_wd;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    map_we = 1'b0;
    map_wa = clr_idx_r;
    map_wd = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        map_we = 1'b1;
      end
      S_EVAL: begin
        map_we = is_evict;
        map_wa = ring_rd_r;
      end
      S_SET: begin
        // rewriting while the output waits is harmless
        map_we = fault_r;
        map_wa = page_r;
        map_wd = 1'b1;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (in_accept) begin
      map_rd_r <= map_mem[PAGE_W'(in_page)];
    end
  end

  // ring: read the oldest entry at accept, append the new page in S_EVAL
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL && is_fault) begin
      ring_mem[ring_tail] <= page_r;
    end
    if (in_accept) begin
      ring_rd_r <= ring_mem[ring_head_r];
    end
  end

  // --------------------------------------------------------------------------
  // Control, configuration, counters and output registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_idx_r        <= '0;
      offset_bits_r    <= fprt_pkg::RST_OFFSET_BITS;
      page_count_r     <= fprt_pkg::RST_PAGE_COUNT;
      frame_cap_r      <= fprt_pkg::RST_FRAME_CAP;
      ring_head_r      <= '0;
      resident_total_r <= '0;
      hit_cnt_r        <= '0;
      fault_cnt_r      <= '0;
      evict_cnt_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      // configuration writes; unknown indexes drop
      if (cfg_we) begin
        unique case (cfg_index)
          fprt_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_wdata[fprt_pkg::OFFSET_CFG_W-1:0];
          fprt_pkg::REG_PAGE_COUNT:  page_count_r  <= cfg_wdata[fprt_pkg::PCOUNT_W-1:0];
          fprt_pkg::REG_FRAME_CAP:   frame_cap_r   <= cfg_wdata[fprt_pkg::FCAP_W-1:0];
          default: ;
        endcase
      end

      // drop a taken result; S_SET handles the output register itself
      if (out_valid_r && !out_stall && state_r != S_SET) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == PAGE_W'(MAX_PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            vaddr_r   <= in_virtual_address;
            page_r    <= PAGE_W'(in_page);
            invalid_r <= in_invalid;
            state_r   <= S_EVAL;
          end
        end
        S_EVAL: begin
          fault_r  <= is_fault;
          evict_r  <= is_evict;
          victim_r <= is_evict ? ring_rd_r : '0;
          if (!invalid_r && map_rd_r && hit_cnt_r != TOTAL_MAX) begin
            hit_cnt_r <= hit_cnt_r + 1'b1;
          end
          if (is_fault) begin
            if (fault_cnt_r != TOTAL_MAX) begin
              fault_cnt_r <= fault_cnt_r + 1'b1;
            end
            // evict plus append leaves the count where it was
            if (is_evict) begin
              ring_head_r <= head_inc;
              if (evict_cnt_r != TOTAL_MAX) begin
                evict_cnt_r <= evict_cnt_r + 1'b1;
              end
            end else begin
              resident_total_r <= resident_total_r + 1'b1;
            end
          end
          state_r <= S_SET;
        end
        S_SET: begin
          // hold here until the output register frees up
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_phys_r      <= invalid_r ? '0 : fprt_pkg::PHYS_W'(vaddr_r);
            out_invalid_r   <= invalid_r;
            out_hit_r       <= !invalid_r && !fault_r;
            out_evict_r     <= evict_r;
            out_victim_r    <= victim_r;
            out_hit_tot_r   <= hit_cnt_r;
            out_fault_tot_r <= fault_cnt_r;
            out_evict_tot_r <= evict_cnt_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_phys_r;
  assign out_address_invalid  = out_invalid_r;
  assign out_page_hit         = out_hit_r;
  assign out_eviction_done    = out_evict_r;
  assign out_evicted_page     = out_victim_r;
  assign out_hit_total        = out_hit_tot_r;
  assign out_fault_total      = out_fault_tot_r;
  assign out_eviction_total   = out_evict_tot_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the ring never holds more pages than it has slots
  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    RT_W'(resident_total_r) <= RT_W'(MAX_FRAMES))
    else $error("resident count exceeds ring depth");

  // a result is a hit, a fault, or invalid, never a hit that also evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evict_r))
    else $error("hit result reports an eviction");

  // invalid requests translate to zero and touch nothing
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_invalid_r) |-> (out_phys_r == '0 && !out_hit_r && !out_evict_r))
    else $error("invalid request produced a translation");

  // a pending result never appears in the cycle right after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EVAL))
    else $error("accepted request skipped evaluation");

  // the fault count only moves in evaluation
  a_fault_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EVAL) |=> $stable(fault_cnt_r))
    else $error("fault count changed outside evaluation");

endmodule

// ===== sim/fifo_page_residency_tracker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_residency_tracker_checker
// Watches the register port and both channels of the page tracker, keeps its
// own copy of the residency state, predicts every result and compares it.
// ----------------------------------------------------------------------------
module fifo_page_residency_tracker_checker
  import fprt_pkg::*;
(
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  cfg_idx_t                                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_wdata,
  input  logic                                      in_valid,
  input  logic                                      in_stall,
  input  logic [DEF_ADDR_BITS-1:0]                  in_virtual_address,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic [PHYS_W-1:0]                         out_physical_address,
  input  logic                                      out_address_invalid,
  input  logic                                      out_page_hit,
  input  logic                                      out_eviction_done,
  input  logic [$clog2(DEF_MAX_PAGES)-1:0]          out_evicted_page,
  input  logic [TOTAL_W-1:0]                        out_hit_total,
  input  logic [TOTAL_W-1:0]                        out_fault_total,
  input  logic [TOTAL_W-1:0]                        out_eviction_total,
  output int unsigned                               mismatch_count,
  output int unsigned                               pending_count
);

  localparam int PAGES        = DEF_MAX_PAGES;
  localparam int FRAMES       = DEF_MAX_FRAMES;
  localparam int PAGE_W       = $clog2(PAGES);
  localparam int SLOT_W       = $clog2(FRAMES);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PHYS_W-1:0]  phys;
    logic               invalid;
    logic               hit;
    logic               evicted;
    logic [PAGE_W-1:0]  victim;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] faults;
    logic [TOTAL_W-1:0] evictions;
  } access_result_t;

  logic [OFFSET_CFG_W-1:0] offset_width;
  logic [PCOUNT_W-1:0]     page_limit;
  logic [FCAP_W-1:0]       frame_limit;

  logic                    page_resident [PAGES];
  logic [PAGE_W-1:0]       arrival_order [FRAMES];
  logic [SLOT_W-1:0]       oldest_slot;
  int unsigned             resident_pages;
  logic [TOTAL_W-1:0]      hit_tally;
  logic [TOTAL_W-1:0]      fault_tally;
  logic [TOTAL_W-1:0]      evict_tally;

  access_result_t          awaited_results [$];

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Translate one address and advance the FIFO residency state.
  function automatic access_result_t translate_access(input logic [DEF_ADDR_BITS-1:0] vaddr);
    access_result_t    r;
    int unsigned       shift;
    int unsigned       limit;
    int unsigned       cap;
    int unsigned       page;
    logic [SLOT_W-1:0] tail;
    r     = '0;
    shift = (offset_width > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_width;
    limit = (page_limit > PAGES) ? PAGES : page_limit;
    cap   = (frame_limit == 0) ? 1 : (frame_limit > FRAMES) ? FRAMES : frame_limit;
    page  = vaddr >> shift;
    if (page >= limit) begin
      r.invalid = 1'b1;
    end else begin
      r.phys = vaddr;
      if (page_resident[page]) begin
        r.hit     = 1'b1;
        hit_tally = bump(hit_tally);
      end else begin
        fault_tally = bump(fault_tally);
        if (resident_pages >= cap) begin
          r.victim                = arrival_order[oldest_slot];
          page_resident[r.victim] = 1'b0;
          oldest_slot             = oldest_slot + 1'b1;
          resident_pages          = resident_pages - 1;
          r.evicted               = 1'b1;
          evict_tally             = bump(evict_tally);
        end
        page_resident[page]  = 1'b1;
        tail                 = oldest_slot + SLOT_W'(resident_pages);
        arrival_order[tail]  = PAGE_W'(page);
        resident_pages       = resident_pages + 1;
      end
    end
    r.hits      = hit_tally;
    r.faults    = fault_tally;
    r.evictions = evict_tally;
    return r;
  endfunction

  task automatic flag_mismatch(input string why, input access_result_t want,
                               input access_result_t seen);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t mismatch (%s)", $realtime, why);
      $display("  expected phys=%h inv=%b hit=%b evict=%b victim=%0d totals=%0d/%0d/%0d",
               want.phys, want.invalid, want.hit, want.evicted, want.victim,
               want.hits, want.faults, want.evictions);
      $display("  actual   phys=%h inv=%b hit=%b evict=%b victim=%0d totals=%0d/%0d/%0d",
               seen.phys, seen.invalid, seen.hit, seen.evicted, seen.victim,
               seen.hits, seen.faults, seen.evictions);
    end
  endtask

  always @(posedge clk) begin
    access_result_t seen;
    access_result_t want;
    if (!rst_n) begin
      offset_width   = RST_OFFSET_BITS;
      page_limit     = RST_PAGE_COUNT;
      frame_limit    = RST_FRAME_CAP;
      oldest_slot    = '0;
      resident_pages = 0;
      hit_tally      = '0;
      fault_tally    = '0;
      evict_tally    = '0;
      mismatch_count = 0;
      foreach (page_resident[i]) page_resident[i] = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_BITS: offset_width = cfg_wdata[OFFSET_CFG_W-1:0];
          REG_PAGE_COUNT:  page_limit   = cfg_wdata[PCOUNT_W-1:0];
          REG_FRAME_CAP:   frame_limit  = cfg_wdata[FCAP_W-1:0];
          default: ;
        endcase
      end
      // A result can never belong to a request taken at this same edge.
      if (out_valid && !out_stall) begin
        seen = '{phys: out_physical_address, invalid: out_address_invalid,
                 hit: out_page_hit, evicted: out_eviction_done,
                 victim: out_evicted_page, hits: out_hit_total,
                 faults: out_fault_total, evictions: out_eviction_total};
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with nothing awaited", '0, seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) flag_mismatch("field differs", want, seen);
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(translate_access(in_virtual_address));
    end
    pending_count = awaited_results.size();
  end

endmodule

// ===== sim/fifo_page_residency_tracker_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_residency_tracker_top_test
// Drives address requests into the FIFO page tracker under several register
// settings, with random idling on both channels, and reports the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module fifo_page_residency_tracker_top_test;
  import fprt_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;      // margin after the last result
  localparam int HOLD_CYCLES    = 60;     // long receiver hold-off
  localparam int BURST_MAX      = 17;
  localparam int PHASES         = 12;
  localparam int PHASE_REQUESTS = 146;
  localparam int LIMIT_NS       = 12 * 400000;
  localparam int PAGE_W         = $clog2(DEF_MAX_PAGES);

  // Index with no register behind it; writes to it must be ignored.
  localparam cfg_idx_t REG_SPARE = cfg_idx_t'(3);

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_idx_t                 cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [DEF_ADDR_BITS-1:0] in_virtual_address;
  logic                     out_valid;
  logic                     out_stall;
  logic [PHYS_W-1:0]        out_physical_address;
  logic                     out_address_invalid;
  logic                     out_page_hit;
  logic                     out_eviction_done;
  logic [PAGE_W-1:0]        out_evicted_page;
  logic [TOTAL_W-1:0]       out_hit_total;
  logic [TOTAL_W-1:0]       out_fault_total;
  logic [TOTAL_W-1:0]       out_eviction_total;

  int unsigned              mismatch_count;
  int unsigned              pending_count;

  // Idling odds in percent, per request (gap) and per cycle (stall), set per phase; zero means no idling.
  int unsigned              gap_pct;
  int unsigned              stall_pct;
  bit                       hold_long;

  // Copies of the register values, used only to shape addresses.
  logic [OFFSET_CFG_W-1:0]  offset_shadow;
  logic [PCOUNT_W-1:0]      count_shadow;
  logic [FCAP_W-1:0]        cap_shadow;
  int unsigned              ws_base;

  fifo_page_residency_tracker_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_address_invalid  (out_address_invalid),
    .out_page_hit         (out_page_hit),
    .out_eviction_done    (out_eviction_done),
    .out_evicted_page     (out_evicted_page),
    .out_hit_total        (out_hit_total),
    .out_fault_total      (out_fault_total),
    .out_eviction_total   (out_eviction_total)
  );

  fifo_page_residency_tracker_checker result_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_address_invalid  (out_address_invalid),
    .out_page_hit         (out_page_hit),
    .out_eviction_done    (out_eviction_done),
    .out_evicted_page     (out_evicted_page),
    .out_hit_total        (out_hit_total),
    .out_fault_total      (out_fault_total),
    .out_eviction_total   (out_eviction_total),
    .mismatch_count       (mismatch_count),
    .pending_count        (pending_count)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Write one register at a falling edge; the block takes it at the next
  // rising edge, then the enable drops.
  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_OFFSET_BITS: offset_shadow = value[OFFSET_CFG_W-1:0];
      REG_PAGE_COUNT:  count_shadow  = value[PCOUNT_W-1:0];
      REG_FRAME_CAP:   cap_shadow    = value[FCAP_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one request, with an optional idle burst in front of it. Hold the
  // payload until the request is taken; valid stays high on return so that
  // back-to-back requests need no second assignment in one step.
  task automatic issue(input logic [DEF_ADDR_BITS-1:0] addr);
    int unsigned idle;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      idle = $urandom_range(1, BURST_MAX);
      @(negedge clk);
      in_valid           <= 1'b0;
      in_virtual_address <= $urandom;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_virtual_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering, wait for every awaited result, then let the pipe go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Pick a fresh setting for a phase. Junk goes into the bits above each
  // register's width, since the block must drop them.
  task automatic pick_config(input int phase);
    logic [CFG_DATA_W-1:0]   junk;
    logic [OFFSET_CFG_W-1:0] offs;
    logic [PCOUNT_W-1:0]     pages;
    logic [FCAP_W-1:0]       frames;
    junk = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0:       offs = '0;
      1:       offs = OFFSET_BITS_MAX;
      2:       offs = '1;
      default: offs = OFFSET_CFG_W'($urandom_range(0, 16));
    endcase
    case ($urandom_range(0, 5))
      0:       pages = PCOUNT_W'(1);
      1:       pages = PCOUNT_W'(DEF_MAX_PAGES);
      2:       pages = '1;
      default: pages = PCOUNT_W'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 6))
      0:       frames = FCAP_W'(1);
      1:       frames = FCAP_W'(DEF_MAX_FRAMES);
      2:       frames = '1;
      3:       frames = '0;
      default: frames = FCAP_W'($urandom_range(1, DEF_MAX_FRAMES));
    endcase
    // Force the widest and the narrowest setting on two early phases.
    if (phase == 1) begin
      offs   = OFFSET_BITS_MAX;
      pages  = PCOUNT_W'(DEF_MAX_PAGES);
      frames = FCAP_W'(DEF_MAX_FRAMES);
    end
    if (phase == 2) begin
      offs   = '0;
      pages  = PCOUNT_W'(1);
      frames = FCAP_W'(1);
    end
    set_reg(REG_OFFSET_BITS, {junk[CFG_DATA_W-1:OFFSET_CFG_W], offs});
    set_reg(REG_PAGE_COUNT, pages);
    set_reg(REG_FRAME_CAP, {junk[CFG_DATA_W-1:FCAP_W], frames});
    if ($urandom_range(0, 3) == 0) set_reg(REG_SPARE, junk);
    ws_base = $urandom;
  endtask

  // Most requests land in a working set about half again as large as the
  // frame capacity, so hits, faults and evictions all stay frequent. The
  // rest are raw noise or the first page past the bound.
  function automatic logic [DEF_ADDR_BITS-1:0] make_address();
    int unsigned shift;
    int unsigned limit;
    int unsigned cap;
    int unsigned span;
    int unsigned page;
    int unsigned roll;
    logic [DEF_ADDR_BITS-1:0] offset_mask;
    shift = (offset_shadow > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_shadow;
    limit = (count_shadow > DEF_MAX_PAGES) ? DEF_MAX_PAGES : count_shadow;
    cap   = (cap_shadow == 0) ? 1 : (cap_shadow > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : cap_shadow;
    offset_mask = (DEF_ADDR_BITS'(1) << shift) - 1'b1;
    roll = $urandom_range(0, 99);
    if (limit == 0 || roll < 8) return $urandom;
    span = cap + cap / 2 + 1;
    if (span > limit) span = limit;
    if (roll < 12) page = limit;
    else page = (ws_base % (limit - span + 1)) + $urandom_range(0, span - 1);
    return (DEF_ADDR_BITS'(page) << shift) | (DEF_ADDR_BITS'($urandom) & offset_mask);
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    int unsigned burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_long = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, BURST_MAX);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    bit closing;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_OFFSET_BITS;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_virtual_address = '0;
    gap_pct            = 0;
    stall_pct          = 0;
    hold_long          = 1'b0;
    offset_shadow      = RST_OFFSET_BITS;
    count_shadow       = RST_PAGE_COUNT;
    cap_shadow         = RST_FRAME_CAP;
    ws_base            = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The bitmap clearing pass after reset stalls the first
    // request; issue() simply waits it out.
    gap_pct   = 10;
    stall_pct = 10;
    // Default setting: first fault, hit with an all-ones offset, last valid
    // page, first page past the bound, all-ones address.
    issue(32'h0000_0000);
    issue(32'h0000_0FFF);
    issue(32'h003F_FFFF);
    issue(32'h0040_0000);
    issue(32'hFFFF_FFFF);
    settle();
    // Zero offset width, page count above the maximum, capacity zero. Two
    // pages are resident, so capacity now sits below the resident count.
    set_reg(REG_OFFSET_BITS, '0);
    set_reg(REG_PAGE_COUNT, '1);
    set_reg(REG_FRAME_CAP, '0);
    set_reg(REG_SPARE, '1);
    issue(32'h0000_0001);
    issue(32'h0000_03FF);
    issue(32'h0000_0400);
    issue(32'h0000_0000);
    settle();
    // Offset width too large, page count zero, capacity above the maximum.
    set_reg(REG_OFFSET_BITS, CFG_DATA_W'(31));
    set_reg(REG_PAGE_COUNT, '0);
    set_reg(REG_FRAME_CAP, CFG_DATA_W'(127));
    issue(32'h3FF0_0000);
    issue(32'h0000_0000);
    settle();
    // Residency carries over a change of page count.
    set_reg(REG_PAGE_COUNT, CFG_DATA_W'(DEF_MAX_PAGES));
    issue(32'h3FF0_0000);
    issue(32'hFFF0_0000);
    issue(32'h000F_FFFF);
    settle();
    // Tiny space, two frames: walk the FIFO order through evictions.
    set_reg(REG_OFFSET_BITS, '0);
    set_reg(REG_PAGE_COUNT, CFG_DATA_W'(4));
    set_reg(REG_FRAME_CAP, CFG_DATA_W'(2));
    issue(32'd0);
    issue(32'd1);
    issue(32'd2);
    issue(32'd3);
    issue(32'd0);
    issue(32'd4);

    // Random part, one setting per phase; every phase starts from a drained
    // block so register writes never overlap traffic.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      pick_config(phase);
      closing   = (phase == PHASES - 1);
      gap_pct   = (closing || phase % 4 == 3) ? 0 : $urandom_range(5, 35);
      stall_pct = (closing || phase % 4 == 3) ? 0 : $urandom_range(5, 35);
      if (phase == 0) begin
        // Keep offering back to back while the receiver holds off.
        gap_pct   = 0;
        hold_long = 1'b1;
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) issue(make_address());
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fprt_pkg.sv
rtl/fifo_page_residency_tracker_top.sv
sim/fifo_page_residency_tracker_checker.sv
sim/fifo_page_residency_tracker_top_test.sv
